/* hw/rtl/wbs_pkg.sv */
// Shared constants for the write burst splitter.
// Used by the front end, the job queue, the sequencer and the top level.
package wbs_pkg;

    // Field widths of the request and transaction beats.
    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 13;
    localparam int LEN_W   = 10;
    localparam int OFF_W   = 12;
    localparam int CORE_W  = 12;

    // Addresses whose upper bits are clear belong to the local window.
    localparam int LOCAL_BITS = 20;

    // Transfer sizes in bytes.
    localparam int WORD_BYTES   = 4;
    localparam int DOUBLE_BYTES = 8;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_REQUEST_BYTES = 4096;
    localparam int DEF_DOUBLES_PER_BURST = 64;

    // Depth of the job queue between front end and sequencer.
    localparam int QUEUE_DEPTH = 2;

endpackage

/* hw/rtl/wbs_front.sv */
// Front end of the write burst splitter: takes request beats, saturates the
// count, makes local addresses global and precomputes the head length.
// Depends on wbs_pkg.
module wbs_front #(
    parameter int MAX_REQUEST_BYTES = wbs_pkg::DEF_MAX_REQUEST_BYTES,
    parameter int LW                = $clog2(MAX_REQUEST_BYTES + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [wbs_pkg::CORE_W-1:0] i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [wbs_pkg::ADDR_W-1:0] i_start_address,
    input  logic [wbs_pkg::COUNT_W-1:0] i_byte_count,
    output logic                       o_job_valid,
    input  logic                       i_job_ready,
    output logic [wbs_pkg::ADDR_W-1:0] o_job_addr,
    output logic [LW-1:0]              o_job_left,
    output logic [2:0]                 o_job_head,
    output logic                       o_job_word
);
    import wbs_pkg::*;

    localparam int CMPW = (LW > COUNT_W) ? LW : COUNT_W;

    logic [CORE_W-1:0] r_core_id;
    logic              r_valid;
    logic [ADDR_W-1:0] r_addr;
    logic [LW-1:0]     r_left;
    logic [2:0]        r_head;
    logic              r_word;

    logic [CMPW-1:0]   count_ext;
    logic [CMPW-1:0]   max_ext;
    logic [LW-1:0]     n_left;
    logic [ADDR_W-1:0] n_addr;
    logic [2:0]        to_boundary;
    logic [2:0]        n_head;
    logic              n_word;
    logic              take;

    // Core number register, written whenever the enable is high.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core_id <= '0;
        end else if (i_cfg_we) begin
            r_core_id <= i_cfg_data;
        end
    end

    // Classify the incoming request.
    always_comb begin
        count_ext = CMPW'(i_byte_count);
        max_ext   = CMPW'(MAX_REQUEST_BYTES);
        n_left    = (count_ext > max_ext) ? LW'(max_ext) : LW'(count_ext);

        // A local address gets the core number in its upper bits.
        if (i_start_address[ADDR_W-1:LOCAL_BITS] == '0) begin
            n_addr = {r_core_id, i_start_address[LOCAL_BITS-1:0]};
        end else begin
            n_addr = i_start_address;
        end

        // Single bytes up to the next double boundary, never beyond the count.
        to_boundary = 3'd0 - n_addr[2:0];
        n_head      = (n_left < LW'(to_boundary)) ? n_left[2:0] : to_boundary;
        n_word      = (n_left == LW'(WORD_BYTES)) && (n_addr[1:0] == 2'b00);
    end

    assign o_ready = !r_valid || i_job_ready;
    assign take    = i_valid && o_ready;

    // Holding register; empty requests are dropped here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= take && (n_left != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_addr <= n_addr;
            r_left <= n_left;
            r_head <= n_head;
            r_word <= n_word;
        end
    end

    assign o_job_valid = r_valid;
    assign o_job_addr  = r_addr;
    assign o_job_left  = r_left;
    assign o_job_head  = r_head;
    assign o_job_word  = r_word;

endmodule

/* hw/rtl/wbs_fifo.sv */
// Short register queue that decouples the front end from the sequencer.
// Depends on wbs_pkg for the default depth.
module wbs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = wbs_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_valid,
    output logic             o_wr_ready,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_rd_valid,
    input  logic             i_rd_ready,
    output logic [WIDTH-1:0] o_rd_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             push;
    logic             pop;

    assign o_wr_ready = (r_count != CW'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

/* hw/rtl/wbs_back.sv */
// Sequencer of the write burst splitter: walks one job and issues one
// transaction beat per cycle into the output register unless it is stalled.
// Depends on wbs_pkg.
module wbs_back #(
    parameter int MAX_REQUEST_BYTES = wbs_pkg::DEF_MAX_REQUEST_BYTES,
    parameter int DOUBLES_PER_BURST = wbs_pkg::DEF_DOUBLES_PER_BURST,
    parameter int LW                = $clog2(MAX_REQUEST_BYTES + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_valid,
    output logic                       o_job_ready,
    input  logic [wbs_pkg::ADDR_W-1:0] i_job_addr,
    input  logic [LW-1:0]              i_job_left,
    input  logic [2:0]                 i_job_head,
    input  logic                       i_job_word,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [wbs_pkg::ADDR_W-1:0] o_target_address,
    output logic [wbs_pkg::LEN_W-1:0]  o_piece_length,
    output logic [wbs_pkg::OFF_W-1:0]  o_buffer_offset,
    output logic                       o_last_piece
);
    import wbs_pkg::*;

    localparam int BURST = DOUBLES_PER_BURST * DOUBLE_BYTES;
    localparam int BW    = $clog2(BURST + 1);
    localparam int BCW   = (LW > BW) ? LW : BW;

    logic              r_busy;
    logic [ADDR_W-1:0] r_addr;
    logic [LW-1:0]     r_left;
    logic [OFF_W-1:0]  r_off;
    logic [2:0]        r_head;
    logic              r_word;

    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_addr;
    logic [LEN_W-1:0]  r_out_len;
    logic [OFF_W-1:0]  r_out_off;
    logic              r_out_last;

    logic [LW-1:0]     len;
    logic [LW-1:0]     n_left;
    logic              last;
    logic              issue;
    logic              load;

    // Pick the size of the next transaction.
    always_comb begin
        priority if (r_word) begin
            len = LW'(WORD_BYTES);
        end else if (r_head != 3'd0) begin
            len = LW'(1);
        end else if (BCW'(r_left) >= BCW'(BURST)) begin
            len = LW'(BURST);
        end else if (r_left[LW-1:3] != '0) begin
            len = {r_left[LW-1:3], 3'b000};
        end else begin
            len = LW'(1);
        end
        n_left = r_left - len;
        last   = (n_left == '0);
    end

    assign issue       = r_busy && (!r_out_valid || i_ready);
    assign o_job_ready = !r_busy;
    assign load        = i_job_valid && !r_busy;

    // Job progress.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (load) begin
            r_busy <= 1'b1;
        end else if (issue && last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_addr <= i_job_addr;
            r_left <= i_job_left;
            r_off  <= '0;
            r_head <= i_job_head;
            r_word <= i_job_word;
        end else if (issue) begin
            r_addr <= r_addr + ADDR_W'(len);
            r_left <= n_left;
            r_off  <= r_off + OFF_W'(len);
            if (r_head != 3'd0) begin
                r_head <= r_head - 3'd1;
            end
        end
    end

    // Output register; the next beat loads as the current one leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            r_out_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_out_addr <= r_addr;
            r_out_len  <= LEN_W'(len);
            r_out_off  <= r_off;
            r_out_last <= last;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_target_address = r_out_addr;
    assign o_piece_length   = r_out_len;
    assign o_buffer_offset  = r_out_off;
    assign o_last_piece     = r_out_last;

endmodule

/* hw/rtl/write_burst_splitter.sv */
// Top level of the write burst splitter: front end, job queue, sequencer.
// Depends on wbs_pkg, wbs_front, wbs_fifo and wbs_back.
//
//   Channel   Direction  Handshake             Beat contents
//   request   in         i_valid / o_ready     start address, byte count
//   piece     out        o_valid / i_ready     target address, length, offset, last
//   config    in         i_cfg_we              core number
//
// The sequencer issues one transaction per cycle unless the output stalls; it
// loads each job before its first transaction and takes the next job only
// after the last transaction of the current one. Empty requests are dropped
// in the front end and reach nothing downstream. Reset is synchronous, active
// low, and empties the queue and output register. A stalled output holds the
// sequencer while the front end keeps filling the queue until it is full.
module write_burst_splitter #(
    parameter int MAX_REQUEST_BYTES = wbs_pkg::DEF_MAX_REQUEST_BYTES,
    parameter int DOUBLES_PER_BURST = wbs_pkg::DEF_DOUBLES_PER_BURST
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [wbs_pkg::CORE_W-1:0]  i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [wbs_pkg::ADDR_W-1:0]  i_start_address,
    input  logic [wbs_pkg::COUNT_W-1:0] i_byte_count,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [wbs_pkg::ADDR_W-1:0]  o_target_address,
    output logic [wbs_pkg::LEN_W-1:0]   o_piece_length,
    output logic [wbs_pkg::OFF_W-1:0]   o_buffer_offset,
    output logic                        o_last_piece
);
    import wbs_pkg::*;

    localparam int LW    = $clog2(MAX_REQUEST_BYTES + 1);
    localparam int JOB_W = ADDR_W + LW + 3 + 1;

    logic              fe_valid;
    logic              fe_ready;
    logic [ADDR_W-1:0] fe_addr;
    logic [LW-1:0]     fe_left;
    logic [2:0]        fe_head;
    logic              fe_word;

    logic              q_valid;
    logic              q_ready;
    logic [JOB_W-1:0]  q_data;

    // Request intake and classification.
    wbs_front #(
        .MAX_REQUEST_BYTES(MAX_REQUEST_BYTES),
        .LW               (LW)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_start_address(i_start_address),
        .i_byte_count   (i_byte_count),
        .o_job_valid    (fe_valid),
        .i_job_ready    (fe_ready),
        .o_job_addr     (fe_addr),
        .o_job_left     (fe_left),
        .o_job_head     (fe_head),
        .o_job_word     (fe_word)
    );

    // Job queue.
    wbs_fifo #(
        .WIDTH(JOB_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_valid(fe_valid),
        .o_wr_ready(fe_ready),
        .i_wr_data ({fe_addr, fe_left, fe_head, fe_word}),
        .o_rd_valid(q_valid),
        .i_rd_ready(q_ready),
        .o_rd_data (q_data)
    );

    // Transaction sequencer.
    wbs_back #(
        .MAX_REQUEST_BYTES(MAX_REQUEST_BYTES),
        .DOUBLES_PER_BURST(DOUBLES_PER_BURST),
        .LW               (LW)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (q_valid),
        .o_job_ready     (q_ready),
        .i_job_addr      (q_data[JOB_W-1 -: ADDR_W]),
        .i_job_left      (q_data[LW+3:4]),
        .i_job_head      (q_data[3:1]),
        .i_job_word      (q_data[0]),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_target_address(o_target_address),
        .o_piece_length  (o_piece_length),
        .o_buffer_offset (o_buffer_offset),
        .o_last_piece    (o_last_piece)
    );

endmodule
